// File: rtl/plti_pkg.sv
// ----------------------------------------------------------------------------
// plti_pkg: shared types and codes for the table interpolator
// Payload structs, action and status codes, default sizes.
// ----------------------------------------------------------------------------
package plti_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 64;
	localparam int DEFAULT_FRAC_BITS   = 16;

	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 7;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FWD  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_INV  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_NOP  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_INTERP   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CLAMP_LO = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLAMP_HI = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]       action;
		logic [INDEX_W-1:0]        entry_index;
		logic signed [VALUE_W-1:0] entry_param;
		logic signed [VALUE_W-1:0] entry_arclen;
		logic signed [VALUE_W-1:0] query_value;
	} plti_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result_value;
		logic [STATUS_W-1:0]       status;
	} plti_out_t;

endpackage

// File: rtl/piecewise_linear_table_interp_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top: paired-table piecewise-linear lookup
// Parameter <-> arc length mapping by binary search and linear interpolation.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------
//   in      | into      | in_valid / in_ready  | in_data  (plti_in_t)
//   out     | out of    | out_valid / out_ready| out_data (plti_out_t)
//   cfg     | into      | cfg_we (no wait)     | cfg_wdata (entry_count)
//
// A load item is written while the sequencer stays idle, and in_ready stays
// high. A query item checks both table ends, runs a binary search with a
// table read on the registered RAM port and a compare per step, reads both
// interval entries, then divides one quotient bit per cycle and multiplies.
// in_ready is low while a query is in flight. A finished result sits in the
// output register; a new item is taken while it waits, and the next query
// stalls at its end only if that register is still full.
// Reset clears the sequencer, output valid and entry_count; table contents
// are undefined until loaded.
//
module piecewise_linear_table_interp_top #(
	parameter int TABLE_DEPTH = plti_pkg::DEFAULT_TABLE_DEPTH,
	parameter int FRAC_BITS   = plti_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  plti_pkg::plti_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output plti_pkg::plti_out_t            out_data,
	input  logic                           cfg_we,
	input  logic [plti_pkg::COUNT_W-1:0]   cfg_wdata
);

	import plti_pkg::*;

	// address, count and datapath widths
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int EW  = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int SW  = VALUE_W + 4;          // shared subtractor
	localparam int DW  = VALUE_W + 1;          // difference of two entries
	localparam int RW  = VALUE_W + 2;          // divider remainder
	localparam int QW  = FRAC_BITS + 1;        // fraction, may equal 1.0
	localparam int KW  = $clog2(FRAC_BITS + 1);
	localparam int SPAN_LO_W = 16;
	localparam int SPAN_HI_W = DW - SPAN_LO_W;
	localparam int PW  = QW + 1 + SPAN_HI_W;   // one partial product
	localparam int ACC_W = FRAC_BITS + VALUE_W + 4;
	localparam int RES_W = VALUE_W + 3;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHK_LO   = 4'd1;
	localparam logic [3:0] S_CHK_HI   = 4'd2;
	localparam logic [3:0] S_SRCH_RD  = 4'd3;
	localparam logic [3:0] S_SRCH_CMP = 4'd4;
	localparam logic [3:0] S_RD_LO    = 4'd5;
	localparam logic [3:0] S_RD_HI    = 4'd6;
	localparam logic [3:0] S_SPAN     = 4'd7;
	localparam logic [3:0] S_NUM      = 4'd8;
	localparam logic [3:0] S_DIV      = 4'd9;
	localparam logic [3:0] S_MUL_LO   = 4'd10;
	localparam logic [3:0] S_MUL_HI   = 4'd11;
	localparam logic [3:0] S_ACC      = 4'd12;
	localparam logic [3:0] S_FIN      = 4'd13;
	localparam logic [3:0] S_DONE     = 4'd14;

	logic [3:0] state_q, state_d;

	logic [COUNT_W-1:0] entry_count_q;
	logic               out_valid_q;
	plti_out_t          out_data_q;

	// per-query registers
	logic signed [VALUE_W-1:0] x_q;
	logic                      dir_q;      // 1: arc length -> parameter
	logic [CW-1:0]             n_q;
	logic [CW-1:0]             lo_q, hi_q, k_q;
	logic signed [VALUE_W-1:0] kl_q, vl_q, vu_q;
	logic [DW-1:0]             d_q;
	logic signed [DW-1:0]      span_q;
	logic [RW-1:0]             rem_q;
	logic [QW-1:0]             quo_q;
	logic [KW-1:0]             div_cnt_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [VALUE_W-1:0] res_val_q;
	logic [STATUS_W-1:0]       res_st_q;

	// handshake
	logic in_fire, is_query, out_free;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign is_query  = (in_data.action == ACT_FWD) || (in_data.action == ACT_INV);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// entry count clipped to the table depth
	logic [EW-1:0] cnt_ext;
	logic [CW-1:0] n_c;
	assign cnt_ext = EW'(entry_count_q);
	assign n_c     = (cnt_ext > EW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(cnt_ext);

	// table RAM: {arclen, param} per entry
	logic [31:0]            idx_ext;
	logic                   ram_we;
	logic [AW-1:0]          ram_raddr;
	logic [CW-1:0]          raddr_c;
	logic [2*VALUE_W-1:0]   ram_rdata;
	logic signed [VALUE_W-1:0] key_rd, val_rd;

	assign idx_ext = 32'(in_data.entry_index);
	assign ram_we  = in_fire && (in_data.action == ACT_LOAD) && (idx_ext < 32'(TABLE_DEPTH));

	plti_ram #(
		.WIDTH (2 * VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_ext[AW-1:0]),
		.wdata ({in_data.entry_arclen, in_data.entry_param}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// forward query searches param, answers arclen; inverse swaps them
	assign key_rd = dir_q ? ram_rdata[2*VALUE_W-1:VALUE_W] : ram_rdata[VALUE_W-1:0];
	assign val_rd = dir_q ? ram_rdata[VALUE_W-1:0] : ram_rdata[2*VALUE_W-1:VALUE_W];

	// search index math
	logic [CW-1:0] mid_c, k_c;
	logic          srch_more;
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
	assign srch_more = (lo_q < hi_q);
	always_comb begin
		if (lo_q < CW'(1)) begin
			k_c = CW'(1);
		end else if (lo_q > n_q - CW'(1)) begin
			k_c = n_q - CW'(1);
		end else begin
			k_c = lo_q;
		end
	end

	// read address: issued in the state before the one that uses the data
	always_comb begin
		unique case (state_q)
			S_CHK_LO:  raddr_c = n_q - CW'(1);
			S_SRCH_RD: raddr_c = srch_more ? mid_c : (k_c - CW'(1));
			S_RD_LO:   raddr_c = k_q;
			default:   raddr_c = '0;
		endcase
	end
	assign ram_raddr = raddr_c[AW-1:0];

	// shared subtractor: compares, interval width, span, numerator, divide
	logic signed [SW-1:0] sub_a, sub_b, sub_d;
	logic                 sub_pos, sub_neg;
	always_comb begin
		unique case (state_q) inside
			S_CHK_LO, S_CHK_HI, S_SRCH_CMP: begin
				sub_a = SW'(x_q);
				sub_b = SW'(key_rd);
			end
			S_RD_HI: begin
				sub_a = SW'(key_rd);
				sub_b = SW'(kl_q);
			end
			S_SPAN: begin
				sub_a = SW'(vu_q);
				sub_b = SW'(vl_q);
			end
			S_NUM: begin
				sub_a = SW'(x_q);
				sub_b = SW'(kl_q);
			end
			S_DIV: begin
				sub_a = SW'(rem_q);
				sub_b = SW'(d_q);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end
	assign sub_d   = sub_a - sub_b;
	assign sub_neg = sub_d[SW-1];
	assign sub_pos = !sub_d[SW-1] && (sub_d != '0);

	// restoring divide step: one quotient bit per cycle
	logic          div_bit;
	logic [RW-1:0] rem_sel;
	assign div_bit = !sub_neg;
	assign rem_sel = div_bit ? RW'(sub_d) : rem_q;

	// fraction times span in two 17-bit halves on one multiplier
	logic signed [QW:0]          mult_a;
	logic signed [SPAN_HI_W-1:0] mult_b;
	logic signed [PW-1:0]        mult_p;
	assign mult_a = {1'b0, quo_q};
	assign mult_b = (state_q == S_MUL_LO) ? {1'b0, span_q[SPAN_LO_W-1:0]}
	                                      : span_q[DW-1:SPAN_LO_W];
	assign mult_p = mult_a * mult_b;

	// lower value plus floored product, saturated to 32 bits
	logic signed [RES_W-1:0]   shifted_c, sum_c;
	logic signed [VALUE_W-1:0] sat_c;
	assign shifted_c = RES_W'(acc_q >>> FRAC_BITS);
	assign sum_c     = RES_W'(vl_q) + shifted_c;
	always_comb begin
		if (sum_c > RES_W'(VAL_MAX)) begin
			sat_c = VAL_MAX;
		end else if (sum_c < RES_W'(VAL_MIN)) begin
			sat_c = VAL_MIN;
		end else begin
			sat_c = VALUE_W'(sum_c);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && is_query) begin
					state_d = (n_c == '0) ? S_DONE : S_CHK_LO;
				end
			end
			S_CHK_LO:   state_d = sub_pos ? S_CHK_HI : S_DONE;
			S_CHK_HI:   state_d = sub_neg ? S_SRCH_RD : S_DONE;
			S_SRCH_RD:  state_d = srch_more ? S_SRCH_CMP : S_RD_LO;
			S_SRCH_CMP: state_d = S_SRCH_RD;
			S_RD_LO:    state_d = S_RD_HI;
			S_RD_HI:    state_d = sub_pos ? S_SPAN : S_DONE;   // zero or negative width: lower value
			S_SPAN:     state_d = S_NUM;
			S_NUM:      state_d = S_DIV;
			S_DIV:      state_d = (div_cnt_q == KW'(FRAC_BITS)) ? S_MUL_LO : S_DIV;
			S_MUL_LO:   state_d = S_MUL_HI;
			S_MUL_HI:   state_d = S_ACC;
			S_ACC:      state_d = S_FIN;
			S_FIN:      state_d = S_DONE;
			S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			entry_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && is_query) begin
					x_q       <= in_data.query_value;
					dir_q     <= (in_data.action == ACT_INV);
					n_q       <= n_c;
					res_val_q <= '0;
					res_st_q  <= ST_EMPTY;
				end
			end
			S_CHK_LO: begin
				lo_q      <= '0;
				hi_q      <= n_q;
				res_val_q <= val_rd;
				res_st_q  <= ST_CLAMP_LO;
			end
			S_CHK_HI: begin
				res_val_q <= val_rd;
				res_st_q  <= ST_CLAMP_HI;
			end
			S_SRCH_RD: begin
				k_q <= k_c;
			end
			S_SRCH_CMP: begin
				// entry below the query: move past it
				if (sub_pos) begin
					lo_q <= mid_c + CW'(1);
				end else begin
					hi_q <= mid_c;
				end
			end
			S_RD_LO: begin
				kl_q      <= key_rd;
				vl_q      <= val_rd;
				res_val_q <= val_rd;
				res_st_q  <= ST_INTERP;
			end
			S_RD_HI: begin
				d_q  <= DW'(sub_d);
				vu_q <= val_rd;
			end
			S_SPAN: begin
				span_q <= DW'(sub_d);
			end
			S_NUM: begin
				rem_q     <= RW'(sub_d);
				quo_q     <= '0;
				div_cnt_q <= '0;
			end
			S_DIV: begin
				rem_q     <= {rem_sel[RW-2:0], 1'b0};
				quo_q     <= {quo_q[QW-2:0], div_bit};
				div_cnt_q <= div_cnt_q + KW'(1);
			end
			S_MUL_LO: begin
				prod_q <= mult_p;
			end
			S_MUL_HI: begin
				acc_q  <= ACC_W'(prod_q);
				prod_q <= mult_p;
			end
			S_ACC: begin
				acc_q <= acc_q + (ACC_W'(prod_q) <<< SPAN_LO_W);
			end
			S_FIN: begin
				res_val_q <= sat_c;
				res_st_q  <= ST_INTERP;
			end
			S_DONE: begin
				if (out_free) begin
					out_data_q.result_value <= res_val_q;
					out_data_q.status       <= res_st_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/plti_ram.sv
// ----------------------------------------------------------------------------
// plti_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module plti_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/plti_checker.sv
// ----------------------------------------------------------------------------
// plti_checker: port-level checks for the table interpolator
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module plti_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input plti_pkg::plti_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input plti_pkg::plti_out_t out_data
);

	import plti_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// an empty table always answers zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |-> out_data.result_value == '0)
		else $error("empty-table result is not zero");

	// a query occupies the sequencer for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.action == ACT_FWD || in_data.action == ACT_INV)
		|=> !in_ready)
		else $error("ready right after a query item");

	// loads and no-op items leave the block ready in the next cycle
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.action == ACT_LOAD || in_data.action == ACT_NOP)
		|=> in_ready)
		else $error("not ready after a load item");

endmodule

bind piecewise_linear_table_interp_top plti_checker u_plti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: tb/sv/piecewise_linear_table_interp_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top_test: self-checking bench for the table interpolator
// Loads paired parameter / arc length tables, sets the entry count and runs
// forward and inverse queries. Each answer is predicted in the bench and
// compared against the block's output.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_top_test;
	import plti_pkg::*;

	localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
	localparam int FRAC           = DEFAULT_FRAC_BITS;
	localparam int SETTLE_CYCLES  = 64;    // above one query's latency at full depth
	localparam int QUIET_LIMIT    = 4000;  // cycles with no item moving on either side
	localparam int SHOWN_FAILS    = 10;

	localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fff_ffff;
	localparam logic signed [VALUE_W-1:0] ONE  = 32'sh0001_0000;   // 1.0 in Q16.16
	localparam longint VMAX_L = 64'sd2147483647;
	localparam longint VMIN_L = -64'sd2147483648;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	plti_in_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	plti_out_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [COUNT_W-1:0]   cfg_wdata = '0;

	// bench copy of the block's state
	logic signed [VALUE_W-1:0] param_tab  [DEPTH];
	logic signed [VALUE_W-1:0] arclen_tab [DEPTH];
	logic [COUNT_W-1:0]        entry_total = '0;

	plti_out_t pending_answers [$];
	int        fail_count  = 0;
	bit        gaps_on     = 1'b1;   // sender idles in bursts
	bit        stall_on    = 1'b1;   // receiver stalls in bursts
	int        stall_left  = 0;

	piecewise_linear_table_interp_top #(
		.TABLE_DEPTH(DEPTH),
		.FRAC_BITS  (FRAC)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// one entry of either table, sign-extended for 64-bit math
	function automatic longint tab_at(bit arclen_side, int i);
		if (arclen_side)
			return longint'(arclen_tab[i]);
		return longint'(param_tab[i]);
	endfunction

	// Search the key table for the first entry not below the query, then
	// interpolate in the paired table. Fraction is truncated to FRAC bits,
	// the scaled product is floored (arithmetic shift on a signed value).
	function automatic plti_out_t interp_lookup(logic [ACTION_W-1:0] act,
	                                            logic signed [VALUE_W-1:0] q);
		plti_out_t res;
		bit        ks;
		int        n, lo, hi, mid, k;
		longint    x, d, num, frac, span, prod, r;
		ks = (act == ACT_INV);
		n  = int'(entry_total);
		if (n > DEPTH)
			n = DEPTH;
		x  = longint'(q);
		res.result_value = '0;
		res.status       = ST_EMPTY;
		if (n == 0)
			return res;
		if (x <= tab_at(ks, 0)) begin
			res.result_value = 32'(tab_at(!ks, 0));
			res.status       = ST_CLAMP_LO;
			return res;
		end
		if (x >= tab_at(ks, n - 1)) begin
			res.result_value = 32'(tab_at(!ks, n - 1));
			res.status       = ST_CLAMP_HI;
			return res;
		end
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tab_at(ks, mid) < x)
				lo = mid + 1;
			else
				hi = mid;
		end
		k = lo;
		if (k < 1)
			k = 1;
		if (k > n - 1)
			k = n - 1;
		res.status = ST_INTERP;
		d = tab_at(ks, k) - tab_at(ks, k - 1);
		if (d <= 0) begin
			// zero-width interval: lower entry of the other table
			res.result_value = 32'(tab_at(!ks, k - 1));
			return res;
		end
		num = x - tab_at(ks, k - 1);
		if (num < 0)
			num = 0;
		if (num > d)
			num = d;
		frac = (num <<< FRAC) / d;
		span = tab_at(!ks, k) - tab_at(!ks, k - 1);
		prod = frac * span;
		r    = tab_at(!ks, k - 1) + (prod >>> FRAC);
		if (r > VMAX_L)
			r = VMAX_L;
		if (r < VMIN_L)
			r = VMIN_L;
		res.result_value = 32'(r);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// random item; fields the action does not use are random as well
	function automatic plti_in_t make_item(logic [ACTION_W-1:0] act);
		plti_in_t it;
		it.action       = act;
		it.entry_index  = INDEX_W'($urandom);
		it.entry_param  = $urandom;
		it.entry_arclen = $urandom;
		it.query_value  = $urandom;
		return it;
	endfunction

	// Drive one item and hold it until accepted. in_valid stays high on
	// return so back-to-back items never drop it within a time step.
	task automatic send_item(plti_in_t item);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// accepted at this edge: advance the bench state
		case (item.action) inside
			ACT_LOAD: begin
				if (int'(item.entry_index) < DEPTH) begin
					param_tab[item.entry_index]  = item.entry_param;
					arclen_tab[item.entry_index] = item.entry_arclen;
				end
			end
			ACT_FWD, ACT_INV: pending_answers.insert(pending_answers.size(),
			                                         interp_lookup(item.action,
			                                                       item.query_value));
			default: ;
		endcase
	endtask

	task automatic load_entry(int idx, logic signed [VALUE_W-1:0] p,
	                          logic signed [VALUE_W-1:0] a);
		plti_in_t it;
		it              = make_item(ACT_LOAD);
		it.entry_index  = INDEX_W'(idx);
		it.entry_param  = p;
		it.entry_arclen = a;
		send_item(it);
	endtask

	task automatic send_query(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] v);
		plti_in_t it;
		it             = make_item(act);
		it.query_value = v;
		send_item(it);
	endtask

	// stop sending, let every answer drain, then give the block time to finish
	// any load or no-op still in flight
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called while idle
	task automatic write_count(logic [COUNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		entry_total  = value;
	endtask

	function automatic int unsigned step_pick();
		case ($urandom_range(0, 3))
			0:       return 3;
			1:       return 32'h0001_0000;
			2:       return 32'h0040_0000;
			default: return 32'h1000_0000;
		endcase
	endfunction

	// query value aimed at the loaded keys: exact hits, near misses,
	// interior points, ends of the number range, and plain noise
	function automatic logic signed [VALUE_W-1:0] pick_query(logic [ACTION_W-1:0] act,
	                                                         int eff);
		bit     ks;
		int     i;
		longint k_lo, k_hi, w;
		ks = (act == ACT_INV);
		if (eff == 0 || $urandom_range(0, 9) == 0)
			return $urandom;
		i    = $urandom_range(0, eff - 1);
		k_lo = tab_at(ks, i);
		case ($urandom_range(0, 5))
			0: return 32'(k_lo);
			1: return 32'(k_lo + longint'($urandom_range(0, 6)) - 3);
			2: return ($urandom_range(0, 1) != 0) ? VMIN : VMAX;
			default: begin
				if (i == eff - 1)
					return 32'(k_lo);
				k_hi = tab_at(ks, i + 1);
				w    = k_hi - k_lo;
				if (w <= 0)
					return 32'(k_lo);
				return 32'(k_lo + longint'($urandom) % (w + 1));
			end
		endcase
	endfunction

	// Fill entries 0..eff-1: ordered tables climb from a random start by
	// random steps (saturating, so duplicates show up), else pure noise.
	task automatic fill_tables(int eff, bit ordered);
		longint      p, a;
		int unsigned p_step, a_step;
		int          i;
		p      = ($urandom_range(0, 3) == 0) ? VMIN_L : longint'(int'($urandom)) / 2;
		a      = ($urandom_range(0, 3) == 0) ? VMIN_L : longint'(int'($urandom)) / 2;
		p_step = step_pick();
		a_step = step_pick();
		for (i = 0; i < eff; i++) begin
			if (ordered) begin
				load_entry(i, 32'(p), 32'(a));
				p = p + longint'($urandom_range(0, p_step));
				a = a + longint'($urandom_range(0, a_step));
				if (p > VMAX_L)
					p = VMAX_L;
				if (a > VMAX_L)
					a = VMAX_L;
			end else begin
				load_entry(i, $urandom, $urandom);
			end
		end
	endtask

	// One setting of the count: drain, write it, load every entry it makes
	// visible, then a mix mostly of queries with a few stray loads and no-ops.
	task automatic run_phase(logic [COUNT_W-1:0] count, bit ordered, int n_items);
		int eff, j, r;
		wait_idle();
		write_count(count);
		eff = (int'(count) > DEPTH) ? DEPTH : int'(count);
		fill_tables(eff, ordered);
		for (j = 0; j < n_items; j++) begin
			r = $urandom_range(0, 99);
			if (r < 46)
				send_query(ACT_FWD, pick_query(ACT_FWD, eff));
			else if (r < 93)
				send_query(ACT_INV, pick_query(ACT_INV, eff));
			else if (r < 96)
				send_item(make_item(ACT_LOAD));
			else
				send_item(make_item(ACT_NOP));
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// count is zero out of reset: every query reports an empty table
	task automatic test_empty_table();
		send_query(ACT_FWD, VMIN);
		send_query(ACT_INV, VMAX);
		send_item(make_item(ACT_NOP));
	endtask

	// one entry: at or below it clamps low, above clamps high
	task automatic test_single_entry();
		load_entry(0, ONE, 5 * ONE);
		wait_idle();
		write_count(7'd1);
		send_query(ACT_FWD, 32'sd0);
		send_query(ACT_FWD, ONE);
		send_query(ACT_FWD, 2 * ONE);
		send_query(ACT_INV, 5 * ONE);
		send_query(ACT_INV, 6 * ONE);
	endtask

	// sorted table spanning the full value range, a repeated parameter and a
	// flat arc length stretch
	task automatic test_interpolation();
		load_entry(0, VMIN, VMIN);
		load_entry(1, -ONE, -3 * ONE);
		load_entry(2, -ONE, 32'sd0);
		load_entry(3, 3 * ONE, 32'sd0);
		load_entry(4, VMAX, VMAX);
		wait_idle();
		write_count(7'd5);
		send_query(ACT_FWD, VMIN);              // equal to first: low clamp
		send_query(ACT_FWD, VMAX);              // equal to last: high clamp
		send_query(ACT_FWD, -ONE);              // exact interior entry
		send_query(ACT_FWD, -32'sd100000);      // wide first interval
		send_query(ACT_FWD, ONE);               // flat arc length, zero span
		send_query(ACT_INV, -5 * ONE);
		send_query(ACT_INV, ONE);
	endtask

	// unsorted keys and a falling arc length: the negative product is floored
	task automatic test_unsorted_table();
		load_entry(0, 32'sd0, 8 * ONE);
		load_entry(1, 4 * ONE, 2 * ONE);
		load_entry(2, ONE, 32'sd3);
		load_entry(3, 6 * ONE, -32'sd7);
		wait_idle();
		write_count(7'd4);
		send_query(ACT_FWD, 3 * ONE + 32'sd5);
		send_query(ACT_FWD, 2 * ONE);
		send_query(ACT_INV, ONE);
	endtask

	// well-formed random tables over several counts, the extremes among them;
	// counts above the depth act as full depth
	task automatic test_ordered_tables();
		run_phase(7'd64, 1'b1, 100);
		run_phase(7'd127, 1'b1, 100);
		run_phase(7'd1, 1'b1, 100);
		run_phase(7'd2, 1'b1, 100);
		run_phase(7'd0, 1'b1, 100);
		run_phase(7'd65, 1'b1, 100);
		run_phase(COUNT_W'($urandom_range(3, 63)), 1'b1, 100);
		run_phase(COUNT_W'($urandom_range(3, 63)), 1'b1, 100);
		run_phase(COUNT_W'($urandom_range(3, 63)), 1'b1, 100);
	endtask

	task automatic test_noisy_tables();
		run_phase(7'd64, 1'b0, 60);
		run_phase(COUNT_W'($urandom_range(2, 127)), 1'b0, 60);
	endtask

	// back-to-back items and an always-ready receiver
	task automatic test_full_rate();
		wait_idle();
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		run_phase(7'd64, 1'b1, 80);
	endtask

	// ------------------------------------------------------------------------
	// Result checking and receiver stalls
	// ------------------------------------------------------------------------

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= SHOWN_FAILS)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk) begin : result_check
		plti_out_t want;
		if (out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				note_failure($sformatf("unexpected result: value %h status %0d",
				                       out_data.result_value, out_data.status));
			end else begin
				want = pending_answers.pop_front();
				if (out_data.result_value !== want.result_value)
					note_failure($sformatf("result_value: expected %h, got %h",
					                       want.result_value, out_data.result_value));
				if (out_data.status !== want.status)
					note_failure($sformatf("status: expected %0d, got %0d",
					                       want.status, out_data.status));
			end
		end
		// random receiver stall bursts
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (stall_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 18);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends the run if no item moves on either channel for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_single_entry();
		test_interpolation();
		test_unsorted_table();
		test_ordered_tables();
		test_noisy_tables();
		test_full_rate();

		wait_idle();
		if (fail_count == 0 && pending_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
